// ===== design/enl_pkg.sv =====
package enl_pkg;

  // field widths
  localparam int ADDR_W  = 32;
  localparam int POS_W   = 24;
  localparam int REV_W   = 8;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;
  localparam int DIFF_W  = 25;
  localparam int MOP_W   = 67;
  localparam int PROD_W  = 134;
  localparam int DIVN_W  = 21;
  localparam int DIVD_W  = 13;

  // etx numerator, 2e6
  localparam logic [DIVN_W-1:0] ETX_NUM = 21'd2000000;
  // stationary-case threshold, 1000 s in 1/256 s units, and the zero min-time limit
  localparam logic [15:0] STILL_LIMIT = 16'd0;
  localparam logic [17:0] STILL_MIN   = 18'd256000;

  // action codes
  localparam logic [2:0] ACT_UPDATE = 3'd0;
  localparam logic [2:0] ACT_TICK   = 3'd1;
  localparam logic [2:0] ACT_ETX    = 3'd2;
  localparam logic [2:0] ACT_HYBRID = 3'd3;
  localparam logic [2:0] ACT_DUMP   = 3'd4;

  // status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_NOTFOUND = 2'd2;
  localparam logic [1:0] STS_EMPTY    = 2'd3;

  // configuration register indexes
  localparam logic REG_RANGE    = 1'b0;
  localparam logic REG_MIN_TIME = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_LET,
    S_DUMP,
    S_RESP
  } state_e;

  // command broadcast to every cell
  typedef struct packed {
    logic                     upd;
    logic                     tick;
    logic                     hit_all;
    logic [ADDR_W-1:0]        addr;
    logic [REV_W-1:0]         rev;
    logic [SLOT_W-1:0]        slot;
    logic [SLOT_W-1:0]        nx;
    logic [SLOT_W-1:0]        cur;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [POS_W-1:0]  vx;
    logic signed [POS_W-1:0]  vy;
  } cell_cmd_t;

  // contents of one cell as seen by the controller
  typedef struct packed {
    logic                     valid;
    logic [ADDR_W-1:0]        key;
    logic [CNT_W-1:0]         count;
    logic [REV_W-1:0]         rev;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [POS_W-1:0]  vx;
    logic signed [POS_W-1:0]  vy;
  } cell_data_t;

endpackage

// ===== design/enl_if.sv =====
interface enl_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [31:0]        neighbor_addr;
  logic [3:0]         probe_slot;
  logic [7:0]         reverse_count;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] vel_x;
  logic signed [23:0] vel_y;

  modport source (output valid, action, neighbor_addr, probe_slot, reverse_count,
                  pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink (input valid, action, neighbor_addr, probe_slot, reverse_count,
                pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface enl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] metric;
  logic [31:0] entry_addr;
  logic [3:0]  probe_count;
  logic        last;

  modport source (output valid, status, metric, entry_addr, probe_count, last,
                  input ready);
  modport sink (input valid, status, metric, entry_addr, probe_count, last,
                output ready);
endinterface

// ===== design/etx_neighbor_link_table.sv =====
// update, tick and not-found queries pass from accept through the execute and respond states
// etx query uses the 21-step serial divider
// hybrid query also runs the link expiration test on the bit-serial multiplier
// dump: one cell per cycle over the table, except while a found entry waits on a stalled result
// one item at a time; a new item is taken once the previous one has its last result queued
// reset clears all valid bits, the current slot and the registers to defaults
module etx_neighbor_link_table #(
  parameter int TABLE_ENTRIES = 32,
  parameter int WINDOW_SLOTS  = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  enl_in_if.sink       item_i,
  enl_out_if.source    result_o,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [19:0]  cfg_data_i
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  enl_pkg::state_e state_q, state_d;

  // configuration
  logic [19:0] range_q;
  logic [15:0] mlt_q;

  // latched transaction
  logic [2:0]                        act_q;
  logic [enl_pkg::ADDR_W-1:0]        addr_q;
  logic [enl_pkg::SLOT_W-1:0]        slot_q;
  logic [enl_pkg::REV_W-1:0]         rev_q;
  logic signed [enl_pkg::POS_W-1:0]  px_q, py_q, vx_q, vy_q;

  // cell row
  enl_pkg::cell_cmd_t   cmd;
  enl_pkg::cell_data_t  cdata [TABLE_ENTRIES];
  enl_pkg::cell_data_t  sel_data, dd;
  logic [TABLE_ENTRIES:0] found_ch, free_ch;
  logic [TABLE_ENTRIES-1:0] sel_vec;
  logic hit, has_free;

  // control
  logic [enl_pkg::SLOT_W-1:0] cur_q, cur_nxt, nx;
  logic [IW:0] didx_q;
  logic        dump_end, dump_take;
  logic        pend_q;
  logic [enl_pkg::ADDR_W-1:0] pend_addr_q;
  logic [enl_pkg::CNT_W-1:0]  pend_cnt_q;
  logic [3:0]  lstep_q;
  logic        lwait_q;
  logic        osl, push_v;

  // result staging and output register
  logic [1:0]  res_sts_q;
  logic [31:0] res_met_q;
  logic [31:0] res_addr_q;
  logic [3:0]  res_cnt_q;
  logic [1:0]  push_sts;
  logic [31:0] push_met, push_addr;
  logic [3:0]  push_cnt;
  logic        push_last;
  logic        out_valid_q;
  logic [1:0]  out_sts_q;
  logic [31:0] out_met_q, out_addr_q;
  logic [3:0]  out_cnt_q;
  logic        out_last_q;

  // arithmetic units
  logic [11:0]                       n_sel;
  logic                              div_start, div_done;
  logic [enl_pkg::DIVN_W-1:0]        quo;
  logic                              mul_start, mul_done;
  logic [enl_pkg::MOP_W-1:0]         ma, mb;
  logic [enl_pkg::PROD_W-1:0]        prod;

  // link expiration datapath
  logic signed [enl_pkg::DIFF_W-1:0] a_q, b_q, c_q, d_q;
  logic [enl_pkg::DIFF_W-1:0]        a_abs, b_abs, c_abs, d_abs;
  logic [49:0]  s_q, s_new;
  logic signed [51:0] x_q, p_q, prod_s, term;
  logic [50:0]  x_abs, p_abs;
  logic [39:0]  r2_q;
  logic [89:0]  sr_q, w_q;
  logic [66:0]  q_q, bp;
  logic         let_fin, let_short, term_neg;

  function automatic logic signed [enl_pkg::DIFF_W-1:0] DIFF_EXT(
    input logic signed [enl_pkg::POS_W-1:0] v
  );
    DIFF_EXT = {v[enl_pkg::POS_W-1], v};
  endfunction

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= 20'd64000;
      mlt_q   <= 16'd256;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == enl_pkg::REG_RANGE) begin
        range_q <= cfg_data_i;
      end else begin
        mlt_q <= cfg_data_i[15:0];
      end
    end
  end

  // slot arithmetic for tick
  always_comb begin
    cur_nxt = ((5'(cur_q) + 5'd1) >= 5'(WINDOW_SLOTS)) ? '0 : cur_q + 1'b1;
    nx      = ((5'(cur_nxt) + 5'd1) >= 5'(WINDOW_SLOTS)) ? '0 : cur_nxt + 1'b1;
  end

  // cell row with first-match and first-free chains
  assign found_ch[0] = 1'b0;
  assign free_ch[0]  = 1'b0;
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    enl_cell #(.WINDOW_SLOTS(WINDOW_SLOTS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .found_i (found_ch[g]),
      .free_i  (free_ch[g]),
      .found_o (found_ch[g+1]),
      .free_o  (free_ch[g+1]),
      .sel_o   (sel_vec[g]),
      .data_o  (cdata[g])
    );
  end
  assign hit      = found_ch[TABLE_ENTRIES];
  assign has_free = free_ch[TABLE_ENTRIES];

  // gather the matching cell
  always_comb begin
    sel_data = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      sel_data = sel_data | (cdata[i] & {$bits(enl_pkg::cell_data_t){sel_vec[i]}});
    end
  end

  // dump walk view
  assign dd        = cdata[didx_q[IW-1:0]];
  assign dump_end  = didx_q == (IW+1)'(TABLE_ENTRIES);
  assign dump_take = dd.valid && (dd.count != '0);

  assign n_sel = 12'(13'(sel_data.count) * 13'(sel_data.rev));

  enl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (enl_pkg::ETX_NUM + enl_pkg::DIVN_W'(n_sel)),
    .den_i   ({n_sel, 1'b0}),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // magnitudes for the serial multiplier
  assign a_abs = a_q[enl_pkg::DIFF_W-1] ? enl_pkg::DIFF_W'(-a_q) : enl_pkg::DIFF_W'(a_q);
  assign b_abs = b_q[enl_pkg::DIFF_W-1] ? enl_pkg::DIFF_W'(-b_q) : enl_pkg::DIFF_W'(b_q);
  assign c_abs = c_q[enl_pkg::DIFF_W-1] ? enl_pkg::DIFF_W'(-c_q) : enl_pkg::DIFF_W'(c_q);
  assign d_abs = d_q[enl_pkg::DIFF_W-1] ? enl_pkg::DIFF_W'(-d_q) : enl_pkg::DIFF_W'(d_q);
  assign x_abs = x_q[51] ? 51'(-x_q) : 51'(x_q);
  assign p_abs = p_q[51] ? 51'(-p_q) : 51'(p_q);
  assign bp    = 67'({p_abs, 8'd0});

  // operand select per step
  always_comb begin
    unique case (lstep_q)
      4'd0:    begin ma = 67'(a_abs); mb = 67'(a_abs); end
      4'd1:    begin ma = 67'(c_abs); mb = 67'(c_abs); end
      4'd2:    begin ma = 67'(a_abs); mb = 67'(d_abs); end
      4'd3:    begin ma = 67'(b_abs); mb = 67'(c_abs); end
      4'd4:    begin ma = 67'(a_abs); mb = 67'(b_abs); end
      4'd5:    begin ma = 67'(c_abs); mb = 67'(d_abs); end
      4'd6:    begin ma = 67'(range_q); mb = 67'(range_q); end
      4'd7:    begin ma = 67'(s_q); mb = 67'(r2_q); end
      4'd8:    begin ma = 67'(x_abs); mb = 67'(x_abs); end
      4'd9:    begin ma = 67'(mlt_q); mb = 67'(s_q); end
      default: begin ma = q_q; mb = q_q; end
    endcase
  end

  enl_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (ma),
    .b_i     (mb),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // signed product term for the cross and dot products
  assign prod_s = signed'(prod[51:0]);
  always_comb begin
    unique case (lstep_q)
      4'd2:    term_neg = a_q[24] ^ d_q[24];
      4'd3:    term_neg = b_q[24] ^ c_q[24];
      4'd4:    term_neg = a_q[24] ^ b_q[24];
      default: term_neg = c_q[24] ^ d_q[24];
    endcase
    term = term_neg ? -prod_s : prod_s;
  end

  // early exits and final compare of the expiration test
  assign s_new = s_q + prod[49:0];
  always_comb begin
    let_fin   = 1'b0;
    let_short = 1'b0;
    unique case (lstep_q)
      4'd1: begin
        if (s_new == '0) begin
          let_fin   = 1'b1;
          let_short = 18'(mlt_q) > enl_pkg::STILL_MIN;
        end
      end
      4'd8: begin
        if (100'(sr_q) < prod[99:0]) begin
          let_fin   = 1'b1;
          let_short = mlt_q != enl_pkg::STILL_LIMIT;
        end else if (mlt_q == enl_pkg::STILL_LIMIT) begin
          let_fin = 1'b1;
        end
      end
      4'd9: begin
        if (p_q[51] && (prod[66:0] <= bp)) begin
          let_fin = 1'b1;
        end
      end
      4'd10: begin
        let_fin   = 1'b1;
        let_short = enl_pkg::PROD_W'({w_q, 16'd0}) < prod;
      end
      default: begin
        let_fin = 1'b0;
      end
    endcase
  end

  assign osl = !out_valid_q || result_o.ready;

  // next state and control outputs
  always_comb begin
    state_d     = state_q;
    item_i.ready = (state_q == enl_pkg::S_IDLE);
    div_start   = 1'b0;
    mul_start   = 1'b0;
    push_v      = 1'b0;
    push_sts    = res_sts_q;
    push_met    = res_met_q;
    push_addr   = res_addr_q;
    push_cnt    = res_cnt_q;
    push_last   = 1'b1;
    cmd         = '0;
    cmd.addr    = addr_q;
    cmd.rev     = rev_q;
    cmd.slot    = slot_q;
    cmd.nx      = nx;
    cmd.cur     = cur_q;
    cmd.hit_all = hit;
    cmd.px      = px_q;
    cmd.py      = py_q;
    cmd.vx      = vx_q;
    cmd.vy      = vy_q;
    unique case (state_q)
      enl_pkg::S_IDLE: begin
        if (item_i.valid) begin
          state_d = enl_pkg::S_EXEC;
        end
      end
      enl_pkg::S_EXEC: begin
        priority case (act_q)
          enl_pkg::ACT_UPDATE: begin
            cmd.upd = hit || has_free;
            state_d = enl_pkg::S_RESP;
          end
          enl_pkg::ACT_TICK: begin
            cmd.tick = 1'b1;
            state_d  = enl_pkg::S_RESP;
          end
          enl_pkg::ACT_ETX, enl_pkg::ACT_HYBRID: begin
            if (!hit || n_sel == '0) begin
              state_d = enl_pkg::S_RESP;
            end else begin
              div_start = 1'b1;
              state_d   = enl_pkg::S_DIV;
            end
          end
          enl_pkg::ACT_DUMP: begin
            state_d = enl_pkg::S_DUMP;
          end
          default: begin
            state_d = enl_pkg::S_IDLE;
          end
        endcase
      end
      enl_pkg::S_DIV: begin
        if (div_done) begin
          state_d = (act_q == enl_pkg::ACT_HYBRID) ? enl_pkg::S_LET : enl_pkg::S_RESP;
        end
      end
      enl_pkg::S_LET: begin
        if (!lwait_q) begin
          mul_start = 1'b1;
        end else if (mul_done && let_fin) begin
          state_d = enl_pkg::S_RESP;
        end
      end
      enl_pkg::S_DUMP: begin
        if (dump_end) begin
          state_d = enl_pkg::S_RESP;
        end else if (dump_take && pend_q) begin
          push_v    = 1'b1;
          push_sts  = enl_pkg::STS_OK;
          push_met  = '0;
          push_addr = pend_addr_q;
          push_cnt  = pend_cnt_q[3:0];
          push_last = 1'b0;
        end
      end
      enl_pkg::S_RESP: begin
        push_v = 1'b1;
        if (osl) begin
          state_d = enl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = enl_pkg::S_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= enl_pkg::S_IDLE;
      cur_q       <= '0;
      didx_q      <= '0;
      pend_q      <= 1'b0;
      lstep_q     <= '0;
      lwait_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (push_v && osl) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        enl_pkg::S_EXEC: begin
          lstep_q <= '0;
          lwait_q <= 1'b0;
          didx_q  <= '0;
          pend_q  <= 1'b0;
          if (act_q == enl_pkg::ACT_TICK) begin
            cur_q <= cur_nxt;
          end
        end
        enl_pkg::S_LET: begin
          if (!lwait_q) begin
            lwait_q <= 1'b1;
          end else if (mul_done) begin
            lwait_q <= 1'b0;
            lstep_q <= lstep_q + 1'b1;
          end
        end
        enl_pkg::S_DUMP: begin
          if (!dump_end) begin
            if (!dump_take) begin
              didx_q <= didx_q + 1'b1;
            end else if (!pend_q || osl) begin
              pend_q <= 1'b1;
              didx_q <= didx_q + 1'b1;
            end
          end
        end
        default: begin
          lwait_q <= lwait_q;
        end
      endcase
    end
  end

  // transaction latch and datapath registers
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      act_q  <= item_i.action;
      addr_q <= item_i.neighbor_addr;
      slot_q <= item_i.probe_slot;
      rev_q  <= item_i.reverse_count;
      px_q   <= item_i.pos_x;
      py_q   <= item_i.pos_y;
      vx_q   <= item_i.vel_x;
      vy_q   <= item_i.vel_y;
    end
    if (push_v && osl) begin
      out_sts_q  <= push_sts;
      out_met_q  <= push_met;
      out_addr_q <= push_addr;
      out_cnt_q  <= push_cnt;
      out_last_q <= push_last;
    end
    unique case (state_q)
      enl_pkg::S_EXEC: begin
        res_addr_q <= '0;
        res_cnt_q  <= '0;
        res_met_q  <= '0;
        res_sts_q  <= enl_pkg::STS_OK;
        a_q <= DIFF_EXT(vx_q) - DIFF_EXT(sel_data.vx);
        b_q <= DIFF_EXT(px_q) - DIFF_EXT(sel_data.px);
        c_q <= DIFF_EXT(vy_q) - DIFF_EXT(sel_data.vy);
        d_q <= DIFF_EXT(py_q) - DIFF_EXT(sel_data.py);
        if (act_q == enl_pkg::ACT_UPDATE && !hit && !has_free) begin
          res_sts_q <= enl_pkg::STS_FULL;
        end
        if (act_q == enl_pkg::ACT_ETX || act_q == enl_pkg::ACT_HYBRID) begin
          if (!hit) begin
            res_sts_q <= enl_pkg::STS_NOTFOUND;
            res_met_q <= '1;
          end else if (n_sel == '0) begin
            res_met_q <= '1;
          end
        end
      end
      enl_pkg::S_DIV: begin
        if (div_done) begin
          res_met_q <= 32'(quo);
        end
      end
      enl_pkg::S_LET: begin
        if (lwait_q && mul_done) begin
          unique case (lstep_q)
            4'd0: s_q  <= prod[49:0];
            4'd1: s_q  <= s_new;
            4'd2: x_q  <= term;
            4'd3: x_q  <= x_q - term;
            4'd4: p_q  <= term;
            4'd5: p_q  <= p_q + term;
            4'd6: r2_q <= prod[39:0];
            4'd7: sr_q <= prod[89:0];
            4'd8: w_q  <= sr_q - prod[89:0];
            4'd9: q_q  <= p_q[51] ? prod[66:0] - bp : prod[66:0] + bp;
            default: q_q <= q_q;
          endcase
          if (let_fin && let_short) begin
            res_met_q <= '1;
          end
        end
      end
      enl_pkg::S_DUMP: begin
        if (!dump_end && dump_take && (!pend_q || osl)) begin
          pend_addr_q <= dd.key;
          pend_cnt_q  <= dd.count;
        end
        if (dump_end) begin
          res_met_q  <= '0;
          res_sts_q  <= pend_q ? enl_pkg::STS_OK : enl_pkg::STS_EMPTY;
          res_addr_q <= pend_q ? pend_addr_q : '0;
          res_cnt_q  <= pend_q ? pend_cnt_q[3:0] : '0;
        end
      end
      default: begin
        res_sts_q <= res_sts_q;
      end
    endcase
  end

  // result port
  assign result_o.valid       = out_valid_q;
  assign result_o.status      = out_sts_q;
  assign result_o.metric      = out_met_q;
  assign result_o.entry_addr  = out_addr_q;
  assign result_o.probe_count = out_cnt_q;
  assign result_o.last        = out_last_q;

  // unused actions produce nothing and return to idle
  a_unused_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == enl_pkg::S_EXEC && act_q > enl_pkg::ACT_DUMP) |=>
      (state_q == enl_pkg::S_IDLE && !(push_v && osl && $past(push_v))))
    else $error("unused action did not return to idle");

  // current slot stays inside the window
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    5'(cur_q) < 5'(WINDOW_SLOTS))
    else $error("current slot out of window");

  // divider completes only while waiting for it
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == enl_pkg::S_DIV)
    else $error("divider done outside divide state");

  // multiplier completes only while the expiration test waits on it
  a_mul_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == enl_pkg::S_LET && lwait_q))
    else $error("multiplier done outside expiration test");

endmodule

// ===== design/enl_cell.sv =====
module enl_cell #(
  parameter int WINDOW_SLOTS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  enl_pkg::cell_cmd_t    cmd_i,
  input  logic                  found_i,
  input  logic                  free_i,
  output logic                  found_o,
  output logic                  free_o,
  output logic                  sel_o,
  output enl_pkg::cell_data_t   data_o
);

  logic                                valid_q;
  logic [enl_pkg::ADDR_W-1:0]          key_q;
  logic [WINDOW_SLOTS-1:0]             map_q;
  logic [enl_pkg::REV_W-1:0]           rev_q;
  logic signed [enl_pkg::POS_W-1:0]    px_q, py_q, vx_q, vy_q;
  logic                                match, sel_free, wr;
  logic [WINDOW_SLOTS-1:0]             slot_bit, clr_bit;
  logic [enl_pkg::CNT_W-1:0]           cnt;
  logic [enl_pkg::SLOT_W:0]            cur_p1;

  // key match and first-hit / first-free chain
  assign match    = valid_q && (key_q == cmd_i.addr);
  assign sel_o    = match && !found_i;
  assign found_o  = found_i || match;
  assign sel_free = !valid_q && !free_i;
  assign free_o   = free_i || !valid_q;
  assign wr       = cmd_i.upd && (sel_o || (!cmd_i.hit_all && sel_free));

  // slot decode and probe count
  assign cur_p1 = {1'b0, cmd_i.cur} + 1'b1;
  always_comb begin
    cnt = '0;
    for (int j = 0; j < WINDOW_SLOTS; j++) begin
      slot_bit[j] = (cmd_i.slot == enl_pkg::SLOT_W'(j));
      clr_bit[j]  = cmd_i.tick && (cmd_i.nx == enl_pkg::SLOT_W'(j));
      if (({1'b0, cmd_i.cur} != (enl_pkg::SLOT_W+1)'(j)) &&
          (cur_p1 != (enl_pkg::SLOT_W+1)'(j))) begin
        cnt = cnt + enl_pkg::CNT_W'(map_q[j]);
      end
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr) begin
      valid_q <= 1'b1;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (wr) begin
      key_q <= cmd_i.addr;
      map_q <= (valid_q ? map_q : '0) | slot_bit;
      rev_q <= cmd_i.rev;
      px_q  <= cmd_i.px;
      py_q  <= cmd_i.py;
      vx_q  <= cmd_i.vx;
      vy_q  <= cmd_i.vy;
    end else if (cmd_i.tick) begin
      map_q <= map_q & ~clr_bit;
    end
  end

  assign data_o.valid = valid_q;
  assign data_o.key   = key_q;
  assign data_o.count = cnt;
  assign data_o.rev   = rev_q;
  assign data_o.px    = px_q;
  assign data_o.py    = py_q;
  assign data_o.vx    = vx_q;
  assign data_o.vy    = vy_q;

endmodule

// ===== design/enl_div.sv =====
module enl_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [enl_pkg::DIVN_W-1:0]  num_i,
  input  logic [enl_pkg::DIVD_W-1:0]  den_i,
  output logic                        done_o,
  output logic [enl_pkg::DIVN_W-1:0]  quo_o
);

  logic                        busy_q, done_q;
  logic [4:0]                  cnt_q;
  logic [enl_pkg::DIVN_W-1:0]  num_q, quo_q;
  logic [enl_pkg::DIVD_W-1:0]  den_q, rem_q;
  logic [enl_pkg::DIVD_W:0]    rem_t;
  logic                        ge;

  // one restoring step per cycle
  assign rem_t = {rem_q, num_q[enl_pkg::DIVN_W-1]};
  assign ge    = rem_t >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'(enl_pkg::DIVN_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[enl_pkg::DIVN_W-2:0], 1'b0};
      rem_q <= ge ? enl_pkg::DIVD_W'(rem_t - {1'b0, den_q})
                  : rem_t[enl_pkg::DIVD_W-1:0];
      quo_q <= {quo_q[enl_pkg::DIVN_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== design/enl_mul.sv =====
module enl_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [enl_pkg::MOP_W-1:0]   a_i,
  input  logic [enl_pkg::MOP_W-1:0]   b_i,
  output logic                        done_o,
  output logic [enl_pkg::PROD_W-1:0]  prod_o
);

  logic                        busy_q, done_q;
  logic [6:0]                  cnt_q;
  logic [enl_pkg::PROD_W-1:0]  a_q, acc_q;
  logic [enl_pkg::MOP_W-1:0]   b_q;

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 7'(enl_pkg::MOP_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= enl_pkg::PROD_W'(a_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[enl_pkg::PROD_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[enl_pkg::MOP_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== bench/link_table_checker.sv =====
module link_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  enl_in_if           item_mon,
  enl_out_if          result_mon,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [19:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 32;
  localparam int SLOTS   = 12;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] metric;
    logic [31:0] entry_addr;
    logic [3:0]  probe_count;
    logic        last;
  } link_result_t;

  link_result_t due_results[$];

  // shadow copy of the neighbor table
  logic               nb_used [ENTRIES];
  logic [31:0]        nb_key  [ENTRIES];
  logic [11:0]        nb_map  [ENTRIES];
  logic [7:0]         nb_rev  [ENTRIES];
  logic signed [23:0] nb_px   [ENTRIES];
  logic signed [23:0] nb_py   [ENTRIES];
  logic signed [23:0] nb_vx   [ENTRIES];
  logic signed [23:0] nb_vy   [ENTRIES];
  logic [3:0]         cur_slot;
  logic [19:0]        radio_range;
  logic [15:0]        min_time;

  int errors;
  assign errors_o  = errors;
  assign pending_o = due_results.size();

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int find_neighbor(logic [31:0] addr);
    for (int i = 0; i < ENTRIES; i++)
      if (nb_used[i] && nb_key[i] == addr) return i;
    return -1;
  endfunction

  // received probes, leaving out the current slot and the one after it
  function automatic logic [3:0] count_probes(logic [11:0] map);
    int n;
    n = 0;
    for (int j = 0; j < SLOTS; j++)
      if (j != int'(cur_slot) && j != int'(cur_slot) + 1) n += map[j];
    return 4'(n);
  endfunction

  function automatic logic [31:0] etx_metric(int e);
    logic [31:0] n;
    n = 32'(count_probes(nb_map[e])) * 32'(nb_rev[e]);
    if (n == 0) return '1;
    return (32'd2000000 + n) / (2 * n);
  endfunction

  function automatic longint abs_ll(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // true when the predicted link lifetime is under the threshold
  function automatic bit link_expires(int e, logic signed [23:0] px, logic signed [23:0] py,
                                      logic signed [23:0] vx, logic signed [23:0] vy);
    longint a, b, c, d, cross_prod, dot;
    logic [159:0] s, r2, sr, x2, w, ms, bp, q, q2, m;
    a = longint'(vx) - longint'(nb_vx[e]);
    b = longint'(px) - longint'(nb_px[e]);
    c = longint'(vy) - longint'(nb_vy[e]);
    d = longint'(py) - longint'(nb_py[e]);
    s = 160'(a * a + c * c);
    m = 160'(min_time);
    if (s == 0) return m > 160'(enl_pkg::STILL_MIN);
    cross_prod = a * d - b * c;
    dot        = a * b + c * d;
    r2 = 160'(radio_range);
    r2 = r2 * r2;
    sr = s * r2;
    x2 = 160'(abs_ll(cross_prod));
    x2 = x2 * x2;
    if (sr < x2) return m != 0;
    w = sr - x2;
    if (m == 0) return 1'b0;
    ms = m * s;
    bp = 160'(abs_ll(dot)) << 8;
    if (dot >= 0) begin
      q = ms + bp;
    end else begin
      if (ms <= bp) return 1'b0;
      q = ms - bp;
    end
    q2 = q * q;
    return (w << 16) < q2;
  endfunction

  // apply one accepted transaction to the shadow table and queue its results
  task automatic apply_link_item();
    link_result_t r;
    int e, n, nx;
    logic [3:0] cnt;
    r = '0;
    r.last = 1'b1;
    e = find_neighbor(item_mon.neighbor_addr);
    case (item_mon.action)
      enl_pkg::ACT_UPDATE: begin
        if (e < 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (!nb_used[i] && e < 0) e = i;
          if (e >= 0) begin
            nb_used[e] = 1'b1;
            nb_key[e]  = item_mon.neighbor_addr;
            nb_map[e]  = '0;
          end
        end
        if (e < 0) begin
          r.status = enl_pkg::STS_FULL;
        end else begin
          nb_rev[e] = item_mon.reverse_count;
          if (item_mon.probe_slot < SLOTS) nb_map[e][item_mon.probe_slot] = 1'b1;
          nb_px[e] = item_mon.pos_x;
          nb_py[e] = item_mon.pos_y;
          nb_vx[e] = item_mon.vel_x;
          nb_vy[e] = item_mon.vel_y;
          r.status = enl_pkg::STS_OK;
        end
        due_results.push_back(r);
      end
      enl_pkg::ACT_TICK: begin
        cur_slot = (cur_slot + 1 >= SLOTS) ? 4'd0 : cur_slot + 4'd1;
        nx = (cur_slot + 1 >= SLOTS) ? 0 : int'(cur_slot) + 1;
        for (int i = 0; i < ENTRIES; i++)
          if (nb_used[i]) nb_map[i][nx] = 1'b0;
        due_results.push_back(r);
      end
      enl_pkg::ACT_ETX, enl_pkg::ACT_HYBRID: begin
        if (e < 0) begin
          r.status = enl_pkg::STS_NOTFOUND;
          r.metric = '1;
        end else begin
          r.metric = etx_metric(e);
          if (item_mon.action == enl_pkg::ACT_HYBRID &&
              link_expires(e, item_mon.pos_x, item_mon.pos_y, item_mon.vel_x, item_mon.vel_y))
            r.metric = '1;
        end
        due_results.push_back(r);
      end
      enl_pkg::ACT_DUMP: begin
        n = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          cnt = nb_used[i] ? count_probes(nb_map[i]) : 4'd0;
          if (cnt != 0) begin
            r = '0;
            r.entry_addr  = nb_key[i];
            r.probe_count = cnt;
            due_results.push_back(r);
            n++;
          end
        end
        if (n == 0) begin
          r = '0;
          r.status = enl_pkg::STS_EMPTY;
          r.last   = 1'b1;
          due_results.push_back(r);
        end else begin
          due_results[$].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // compare results, predict inputs, follow register writes
  always @(posedge clk_i or negedge rst_ni) begin
    link_result_t want;
    if (!rst_ni) begin
      due_results.delete();
      for (int i = 0; i < ENTRIES; i++) nb_used[i] = 1'b0;
      cur_slot    = '0;
      radio_range = 20'd64000;
      min_time    = 16'd256;
      errors      = 0;
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (due_results.size() == 0) begin
          report("unexpected result, status", 32'(result_mon.status), 0);
        end else begin
          want = due_results.pop_front();
          if (result_mon.status !== want.status)
            report("status", 32'(result_mon.status), 32'(want.status));
          if (result_mon.metric !== want.metric)
            report("metric", result_mon.metric, want.metric);
          if (result_mon.entry_addr !== want.entry_addr)
            report("entry_addr", result_mon.entry_addr, want.entry_addr);
          if (result_mon.probe_count !== want.probe_count)
            report("probe_count", 32'(result_mon.probe_count), 32'(want.probe_count));
          if (result_mon.last !== want.last)
            report("last", 32'(result_mon.last), 32'(want.last));
        end
      end
      if (item_mon.valid && item_mon.ready) apply_link_item();
      if (cfg_we_i) begin
        if (cfg_idx_i == enl_pkg::REG_RANGE) radio_range = cfg_data_i;
        else if (cfg_idx_i == enl_pkg::REG_MIN_TIME) min_time = cfg_data_i[15:0];
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 1000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [19:0] cfg_data_i;
  int          errors;
  int          pending;
  int          cycles = 0;
  int          burst_left;
  bit          hold_req;
  logic [31:0] addr_pool [40];

  enl_in_if  item_if ();
  enl_out_if res_if ();

  etx_neighbor_link_table u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_if),
    .result_o   (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  link_table_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_mon   (item_if),
    .result_mon (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("etx_neighbor_link_table: mismatch");
      $finish;
    end
  end

  // result side: changing stall patterns, plus one long hold-off
  initial begin
    int mode;
    bit held;
    res_if.ready <= 1'b0;
    mode = 0;
    held = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1;
        res_if.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= $urandom_range(0, 1);
          default: res_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // offer one transaction, with bursty gaps in front
  task automatic send_item(logic [2:0] act, logic [31:0] addr, logic [3:0] slot,
                           logic [7:0] rev, logic [23:0] px, logic [23:0] py,
                           logic [23:0] vx, logic [23:0] vy);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid         <= 1'b1;
    item_if.action        <= act;
    item_if.neighbor_addr <= addr;
    item_if.probe_slot    <= slot;
    item_if.reverse_count <= rev;
    item_if.pos_x         <= px;
    item_if.pos_y         <= py;
    item_if.vel_x         <= vx;
    item_if.vel_y         <= vy;
    do @(posedge clk_i); while (!item_if.ready);
  endtask

  // let the block drain before touching a register
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [19:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // positions mostly within radio range, sometimes anywhere
  function automatic logic [23:0] rand_pos();
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    return 24'(int'($urandom_range(0, 40000)) - 20000);
  endfunction

  function automatic logic [23:0] rand_vel();
    case ($urandom_range(0, 2))
      0: return 24'd0;
      1: return 24'(int'($urandom_range(0, 5120)) - 2560);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_random();
    logic [2:0] act;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) act = enl_pkg::ACT_UPDATE;
    else if (pick < 60) act = enl_pkg::ACT_TICK;
    else if (pick < 75) act = enl_pkg::ACT_ETX;
    else if (pick < 87) act = enl_pkg::ACT_HYBRID;
    else if (pick < 95) act = enl_pkg::ACT_DUMP;
    else act = 3'($urandom_range(5, 7));
    send_item(act, ($urandom_range(0, 19) == 0) ? $urandom : addr_pool[$urandom_range(0, 39)],
              4'($urandom), 8'($urandom), rand_pos(), rand_pos(), rand_vel(), rand_vel());
  endtask

  // stimulus and verdict
  initial begin
    logic [19:0] ranges [4];
    logic [15:0] times  [4];
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= enl_pkg::REG_RANGE;
    cfg_data_i    <= '0;
    item_if.valid <= 1'b0;
    item_if.action        <= enl_pkg::ACT_UPDATE;
    item_if.neighbor_addr <= '0;
    item_if.probe_slot    <= '0;
    item_if.reverse_count <= '0;
    item_if.pos_x <= '0;
    item_if.pos_y <= '0;
    item_if.vel_x <= '0;
    item_if.vel_y <= '0;
    hold_req   = 0;
    burst_left = 0;
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 40; i++) addr_pool[i] = $urandom;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, out-of-window slot, still and far links
    send_item(enl_pkg::ACT_DUMP, 0, 0, 0, 0, 0, 0, 0);
    send_item(enl_pkg::ACT_ETX, 32'h1234, 0, 0, 0, 0, 0, 0);
    send_item(enl_pkg::ACT_HYBRID, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    send_item(enl_pkg::ACT_UPDATE, 32'h0, 4'd3, 8'd255, 24'h7FFFFF, 24'h7FFFFF,
              24'h7FFFFF, 24'h7FFFFF);
    send_item(enl_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 4'd15, 8'd0, 24'h800000, 24'h800000,
              24'h800000, 24'h800000);
    send_item(enl_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 4'd11, 8'd1, 24'd0, 24'd0, 24'd256, 24'd0);
    send_item(enl_pkg::ACT_UPDATE, 32'h0, 4'd0, 8'd255, 24'd0, 24'd0, 24'd0, 24'd0);
    send_item(enl_pkg::ACT_UPDATE, 32'h0, 4'd5, 8'd255, 24'd0, 24'd0, 24'd0, 24'd0);
    send_item(enl_pkg::ACT_ETX, 32'h0, 0, 0, 0, 0, 0, 0);
    send_item(enl_pkg::ACT_ETX, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    send_item(enl_pkg::ACT_HYBRID, 32'h0, 0, 0, 24'd2560, 24'd0, 24'd0, 24'd0);
    send_item(enl_pkg::ACT_HYBRID, 32'h0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
              24'h7FFFFF);
    send_item(enl_pkg::ACT_HYBRID, 32'hFFFF_FFFF, 0, 0, 24'd2560, 24'd0, 24'd0, 24'd256);
    send_item(enl_pkg::ACT_HYBRID, 32'hFFFF_FFFF, 0, 0, 24'd0, 24'd0, 24'd512, 24'd0);
    send_item(enl_pkg::ACT_DUMP, 0, 0, 0, 0, 0, 0, 0);
    send_item(3'd5, 32'h0, 0, 0, 0, 0, 0, 0);
    send_item(3'd7, 32'h0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 7; i++) send_item(enl_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_item(enl_pkg::ACT_DUMP, 0, 0, 0, 0, 0, 0, 0);

    // random phases over several register settings, extremes included
    ranges[0] = 20'd0;       times[0] = 16'd0;
    ranges[1] = 20'hFFFFF;   times[1] = 16'hFFFF;
    ranges[2] = 20'd64000;   times[2] = 16'd256;
    ranges[3] = 20'($urandom); times[3] = 16'($urandom_range(0, 2048));
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_reg(enl_pkg::REG_RANGE, ranges[ph]);
      write_reg(enl_pkg::REG_MIN_TIME, 20'(times[ph]));
      for (int k = 0; k < 102; k++) begin
        if (ph == 2 && k == 10) hold_req = 1;
        send_random();
      end
    end

    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("etx_neighbor_link_table: match");
    end else begin
      $display("etx_neighbor_link_table: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/enl_pkg.sv
design/enl_if.sv
design/enl_cell.sv
design/enl_div.sv
design/enl_mul.sv
design/etx_neighbor_link_table.sv
bench/link_table_checker.sv
bench/testbench.sv
